// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define CHECK_HOLDS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define CHECK_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define CHECK_HOLDS(label, prop, msg)
`define CHECK_NEXT(label, pre, post, msg)
`endif
`endif

// ===== hw/rtl/lznwd_pkg.sv =====
// Shared constants and types of the nibble window decoder.
package lznwd_pkg;

   localparam int WINDOW_DEPTH     = 16;
   localparam int MAX_MATCH_LENGTH = 9;
   localparam int NIB_W            = 4;
   localparam int IDX_W            = $clog2(WINDOW_DEPTH);
   localparam int LEN_W            = $clog2(MAX_MATCH_LENGTH + 1);
   localparam int MIN_MATCH        = 2;
   localparam int CODE_W           = 8;

   // Control broadcast to every window cell.
   typedef struct packed {
      logic             shift;
      logic             fill;
      logic [NIB_W-1:0] fill_val;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/lznwd_req_if.sv =====
// Input channel: one compressed code byte per transaction.
interface lznwd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       stream_start;

   modport source (output valid, output code_byte, output stream_start, input ready);
   modport sink   (input valid, input code_byte, input stream_start, output ready);
endinterface

// ===== hw/rtl/lznwd_rsp_if.sv =====
// Result channel: one decoded subpixel per transaction.
interface lznwd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] subpixel;
   logic       out_of_window;
   logic       last;

   modport source (output valid, output subpixel, output out_of_window, output last,
                   input ready);
   modport sink   (input valid, input subpixel, input out_of_window, input last,
                   output ready);
endinterface

// ===== hw/rtl/lznwd_cell.sv =====
// One window cell: holds a nibble, loads from its right neighbor or the seed.
module lznwd_cell
   import lznwd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   input  logic [NIB_W-1:0] right_nib,
   output logic [NIB_W-1:0] nib
);

   logic [NIB_W-1:0] nib_ff;
   logic [NIB_W-1:0] nib_in;

   always_comb begin
      nib_in = nib_ff;
      if (ctrl.fill) begin
         nib_in = ctrl.fill_val;
      end else if (ctrl.shift) begin
         nib_in = right_nib;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nib_ff <= '0;
      end else begin
         nib_ff <= nib_in;
      end
   end

   assign nib = nib_ff;

endmodule

// ===== hw/rtl/lz77_nibble_window_decoder.sv =====
// Top level: nibble window decoder built on a shifting row of window cells.
// Each byte is first registered; its results then pass through the output register.
// Throughput: one result per cycle unless the output stalls; a byte yields one result
// for seed and literal, 2..9 for a match. The row shifts one nibble per literal or match
// result. The next byte is taken in the cycle its predecessor's last result is made.
// Reset (synchronous) clears the window to zero and empties the output register at once.
`include "assert_macros.svh"
module lz77_nibble_window_decoder
   import lznwd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   lznwd_req_if.sink   req_chan,
   lznwd_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      KIND_SEED,
      KIND_LITERAL,
      KIND_MATCH
   } kind_type;

   // Byte being decoded.
   logic             busy_ff;
   kind_type         kind_ff;
   logic [NIB_W-1:0] nib_ff;
   logic [IDX_W-1:0] pos_ff;
   // Original window index of the next match read; bit IDX_W set means past the end.
   logic [IDX_W:0]   rd_idx_ff;
   logic [LEN_W-1:0] rem_ff;

   // Output register.
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [7:0]       subpixel_ff;
   logic             oow_ff;
   logic             last_ff;

   logic             req_fire;
   logic             advance;
   logic             finishing;
   logic             read_oow;
   logic [NIB_W-1:0] emit_val;
   logic             emit_oow;
   logic [LEN_W-1:0] match_len;
   kind_type         kind_in;
   cell_ctrl_type    cell_ctrl;
   logic [NIB_W-1:0] window_nib [WINDOW_DEPTH];

   // The window row slides toward entry 0 by one for every literal or match nibble emitted.
   // After k slides, original entry pos+k sits at entry pos, so a match
   // always reads the same cell while the row moves underneath it.
   genvar gi;
   generate
      for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
         logic [NIB_W-1:0] right_nib;
         if (gi == WINDOW_DEPTH - 1) begin : g_tail
            assign right_nib = emit_val;
         end else begin : g_body
            assign right_nib = window_nib[gi + 1];
         end
         lznwd_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .right_nib (right_nib),
            .nib       (window_nib[gi])
         );
      end
   endgenerate

   always_comb begin
      req_fire  = req_chan.valid && req_chan.ready;
      // Produce a result whenever the output register is free or being drained.
      advance   = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
      finishing = advance && (rem_ff == LEN_W'(1));
      req_chan.ready = !busy_ff || finishing;

      read_oow = rd_idx_ff[IDX_W];
      case (kind_ff)
         KIND_SEED:    emit_val = nib_ff;
         KIND_LITERAL: emit_val = nib_ff;
         KIND_MATCH:   emit_val = read_oow ? '0 : window_nib[pos_ff];
         default:      emit_val = nib_ff;
      endcase
      emit_oow = (kind_ff == KIND_MATCH) && read_oow;

      match_len = LEN_W'(req_chan.code_byte[6:4]) + LEN_W'(MIN_MATCH);
      if (req_chan.stream_start) begin
         kind_in = KIND_SEED;
      end else if (req_chan.code_byte[CODE_W-1]) begin
         kind_in = KIND_MATCH;
      end else begin
         kind_in = KIND_LITERAL;
      end

      // Seed fills the whole row; it wins over the last shift of the prior byte.
      cell_ctrl.fill     = req_fire && req_chan.stream_start;
      cell_ctrl.fill_val = req_chan.code_byte[NIB_W-1:0];
      cell_ctrl.shift    = advance && (kind_ff != KIND_SEED);

      // Hold the result until taken; load a new one on advance.
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            busy_ff <= 1'b1;
         end else if (finishing) begin
            busy_ff <= 1'b0;
         end
      end

      if (req_fire) begin
         kind_ff   <= kind_in;
         nib_ff    <= req_chan.code_byte[NIB_W-1:0];
         pos_ff    <= req_chan.code_byte[IDX_W-1:0];
         rd_idx_ff <= {1'b0, req_chan.code_byte[IDX_W-1:0]};
         rem_ff    <= (kind_in == KIND_MATCH) ? match_len : LEN_W'(1);
      end else if (advance) begin
         rem_ff    <= rem_ff - LEN_W'(1);
         rd_idx_ff <= rd_idx_ff + (IDX_W+1)'(1);
      end

      if (advance) begin
         subpixel_ff <= {emit_val, {(8-NIB_W){1'b0}}};
         oow_ff      <= emit_oow;
         last_ff     <= (rem_ff == LEN_W'(1));
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.subpixel      = subpixel_ff;
   assign rsp_chan.out_of_window = oow_ff;
   assign rsp_chan.last          = last_ff;

   `CHECK_HOLDS(a_busy_has_work, busy_ff |-> (rem_ff != '0), "busy with no results left")
   `CHECK_HOLDS(a_single_result,
                (busy_ff && kind_ff != KIND_MATCH) |-> (rem_ff == LEN_W'(1)),
                "seed or literal with more than one result")
   `CHECK_HOLDS(a_oow_zero, (rsp_valid_ff && oow_ff) |-> (subpixel_ff == 8'd0),
                "out-of-window result not zero")
   `CHECK_NEXT(a_finish_or_next, finishing, busy_ff == $past(req_fire), "byte end mishandled")
   `CHECK_HOLDS(a_read_range,
                busy_ff |-> (rd_idx_ff <= (IDX_W+1)'(WINDOW_DEPTH + MAX_MATCH_LENGTH - 1)),
                "match read index overran")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the nibble window decoder: directed table, then random bytes.
`timescale 1ns / 1ps

module testbench
   import lznwd_pkg::*;
;

   // Code byte layout: bit 7 picks literal or match, bits 6..4 hold length minus two.
   localparam int MATCH_BIT = 7;
   localparam int LEN_MSB   = 6;
   localparam int LEN_LSB   = 4;

   // Run sizing.
   localparam int DIRECTED_ROWS   = 25;
   localparam int RANDOM_PER_MIX  = 19;
   localparam int MIX_COUNT       = 4;
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 16;
   localparam int REPORT_LIMIT    = 10;

   // One decoded subpixel as it leaves the block.
   typedef struct packed {
      logic [7:0] subpixel;
      logic       out_of_window;
      logic       last;
   } subpixel_rec_type;

   // One row of the directed table. Rows with has_typed set carry a single
   // result (seed or literal) that is written in by hand; the rest go through
   // the window predictor.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              start;
      logic              has_typed;
      logic [7:0]        typed_sub;
   } code_row_type;

   logic clock = 1'b0;
   logic reset;

   lznwd_req_if req_bus ();
   lznwd_rsp_if rsp_bus ();

   lz77_nibble_window_decoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: the window as the block should hold it, entry 0 oldest.
   logic [NIB_W-1:0] window_model [WINDOW_DEPTH];
   subpixel_rec_type expected_subpixels [$];

   // Idle and stall odds, in percent, for the current traffic mix.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   int error_count    = 0;
   int seed_count     = 0;
   int literal_count  = 0;
   int match_count    = 0;
   int subpixel_count = 0;
   int past_end_count = 0;
   int quiet_cycles   = 0;

   // Directed stimulus: extremes, every kind of byte and each corner of the window.
   code_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'hF8, 1'b0, 1'b0, 8'h00},   // match before any seed: zeros, tail past the end
      '{8'h00, 1'b0, 1'b1, 8'h00},   // smallest literal
      '{8'h0F, 1'b0, 1'b1, 8'hF0},   // largest literal nibble
      '{8'h7A, 1'b0, 1'b1, 8'hA0},   // literal with bits 6..4 set, ignored
      '{8'h05, 1'b1, 1'b1, 8'h50},   // seed fills the window
      '{8'hFF, 1'b1, 1'b1, 8'hF0},   // seed ignores the high nibble
      '{8'h93, 1'b1, 1'b1, 8'h30},   // seed wins over the match flag
      '{8'h00, 1'b1, 1'b1, 8'h00},   // all-zero seed
      '{8'h01, 1'b0, 1'b1, 8'h10},
      '{8'h12, 1'b0, 1'b1, 8'h20},
      '{8'h23, 1'b0, 1'b1, 8'h30},
      '{8'h4C, 1'b0, 1'b1, 8'hC0},
      '{8'h6E, 1'b0, 1'b1, 8'hE0},
      '{8'h7F, 1'b0, 1'b1, 8'hF0},
      '{8'h80, 1'b0, 1'b0, 8'h00},   // shortest match at the oldest entry
      '{8'hF0, 1'b0, 1'b0, 8'h00},   // longest match at the oldest entry
      '{8'hFF, 1'b0, 1'b0, 8'h00},   // longest match from the newest entry, mostly past end
      '{8'h8F, 1'b0, 1'b0, 8'h00},   // shortest match, second nibble past end
      '{8'hF7, 1'b0, 1'b0, 8'h00},   // longest match that ends exactly at the window end
      '{8'hB4, 1'b0, 1'b0, 8'h00},
      '{8'h0B, 1'b0, 1'b1, 8'hB0},
      '{8'hCA, 1'b0, 1'b0, 8'h00},
      '{8'hA9, 1'b0, 1'b0, 8'h00},
      '{8'h8E, 1'b0, 1'b0, 8'h00},
      '{8'hD0, 1'b0, 1'b0, 8'h00}
   };

   // Decode one byte against the window model, fill recs, then slide or refill the window.
   function automatic int decode_byte(input logic [CODE_W-1:0] code, input logic start,
                                      output subpixel_rec_type recs [MAX_MATCH_LENGTH]);
      logic [NIB_W-1:0] nib;
      logic [NIB_W-1:0] old_window [WINDOW_DEPTH];
      int               count;
      int               idx;
      nib        = code[NIB_W-1:0];
      old_window = window_model;
      for (int k = 0; k < MAX_MATCH_LENGTH; k++) recs[k] = '0;
      if (start) begin
         for (int k = 0; k < WINDOW_DEPTH; k++) window_model[k] = nib;
         recs[0].subpixel = {nib, 4'h0};
         recs[0].last     = 1'b1;
         return 1;
      end
      if (!code[MATCH_BIT]) begin
         count            = 1;
         recs[0].subpixel = {nib, 4'h0};
      end else begin
         count = int'(code[LEN_MSB:LEN_LSB]) + MIN_MATCH;
         // Read only the window as it stood before this byte.
         for (int k = 0; k < count; k++) begin
            idx = int'(nib) + k;
            if (idx < WINDOW_DEPTH) recs[k].subpixel = {old_window[idx], 4'h0};
            else recs[k].out_of_window = 1'b1;
         end
      end
      recs[count-1].last = 1'b1;
      // Drop the oldest entries and append what was just decoded.
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (i + count < WINDOW_DEPTH) window_model[i] = old_window[i + count];
         else window_model[i] = recs[i - (WINDOW_DEPTH - count)].subpixel[7 -: NIB_W];
      end
      return count;
   endfunction

   task automatic log_error(input string msg);
      if (error_count < REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Offer one code byte, wait for the transaction, then queue its subpixels.
   task automatic send_code(input logic [CODE_W-1:0] code, input logic start,
                            input logic has_typed, input logic [7:0] typed_sub);
      subpixel_rec_type recs [MAX_MATCH_LENGTH];
      subpixel_rec_type typed_rec;
      int               n;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.code_byte    <= code;
      req_bus.stream_start <= start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      n = decode_byte(code, start, recs);
      if (start) seed_count++;
      else if (code[MATCH_BIT]) match_count++;
      else literal_count++;
      if (has_typed) begin
         typed_rec = '{subpixel: typed_sub, out_of_window: 1'b0, last: 1'b1};
         expected_subpixels.push_back(typed_rec);
      end else begin
         for (int k = 0; k < n; k++) expected_subpixels.push_back(recs[k]);
      end
   endtask

   // Mostly well-formed traffic: literals and matches, with an occasional reseed.
   task automatic send_random_code();
      int               pick;
      logic [2:0]       len_bits;
      logic [NIB_W-1:0] pos;
      pick = $urandom_range(99);
      if (pick < 6) begin
         send_code(CODE_W'($urandom_range(255)), 1'b1, 1'b0, 8'h00);
      end else if (pick < 45) begin
         send_code({1'b0, 7'($urandom_range(127))}, 1'b0, 1'b0, 8'h00);
      end else begin
         len_bits = 3'($urandom_range(7));
         // Keep most matches inside the window; the rest may run past its end.
         if ($urandom_range(99) < 80)
            pos = NIB_W'($urandom_range(WINDOW_DEPTH - MIN_MATCH - int'(len_bits)));
         else
            pos = NIB_W'($urandom_range(WINDOW_DEPTH - 1));
         send_code({1'b1, len_bits, pos}, 1'b0, 1'b0, 8'h00);
      end
   endtask

   // Hold the sender until every queued subpixel has come out.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_subpixels.size() != 0) @(posedge clock);
   endtask

   // Result side: stall at the current odds.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare each result transaction with the oldest queued subpixel, and
   // watch for a stretch with no transaction on either channel.
   always @(posedge clock) begin
      subpixel_rec_type got;
      subpixel_rec_type want;
      logic             req_fire;
      logic             rsp_fire;
      req_fire = req_bus.valid && req_bus.ready;
      rsp_fire = rsp_bus.valid && rsp_bus.ready;
      if (!reset && rsp_fire) begin
         got = '{subpixel: rsp_bus.subpixel, out_of_window: rsp_bus.out_of_window,
                 last: rsp_bus.last};
         subpixel_count++;
         if (got.out_of_window) past_end_count++;
         if (expected_subpixels.size() == 0) begin
            log_error($sformatf("unexpected subpixel %02h oow %0b last %0b",
                                got.subpixel, got.out_of_window, got.last));
         end else begin
            want = expected_subpixels.pop_front();
            if (got.subpixel !== want.subpixel || got.out_of_window !== want.out_of_window ||
                got.last !== want.last)
               log_error($sformatf("subpixel %02h/%02h oow %0b/%0b last %0b/%0b (exp/act)",
                                   want.subpixel, got.subpixel, want.out_of_window,
                                   got.out_of_window, want.last, got.last));
         end
      end
      if (reset || req_fire || rsp_fire) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("ERROR @%0t: no transaction for %0d cycles, %0d subpixels outstanding",
                  $realtime, STALL_LIMIT, expected_subpixels.size());
         $display("lz77_nibble_window_decoder test failed");
         $finish;
      end
   end

   initial begin
      // Mix table: sender idle percent, receiver stall percent.
      int mix_idle  [MIX_COUNT] = '{0, 77, 0, 33};
      int mix_stall [MIX_COUNT] = '{0, 0, 77, 33};
      for (int i = 0; i < WINDOW_DEPTH; i++) window_model[i] = '0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.code_byte    = '0;
      req_bus.stream_start = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table, back to back with no idling.
      foreach (directed_rows[r])
         send_code(directed_rows[r].code, directed_rows[r].start,
                   directed_rows[r].has_typed, directed_rows[r].typed_sub);
      drain_results();

      // Random traffic under each idle/stall mix; drain fully between mixes.
      for (int m = 0; m < MIX_COUNT; m++) begin
         send_idle_pct  = mix_idle[m];
         recv_stall_pct = mix_stall[m];
         repeat (RANDOM_PER_MIX) send_random_code();
         drain_results();
      end

      recv_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_subpixels.size() != 0)
         log_error($sformatf("%0d subpixels never arrived", expected_subpixels.size()));

      $display("Covered %0d code bytes: %0d seeds, %0d literals, %0d matches.",
               seed_count + literal_count + match_count, seed_count, literal_count,
               match_count);
      $display("Checked %0d subpixels (%0d past the window end) under four idle/stall mixes.",
               subpixel_count, past_end_count);
      if (error_count == 0) begin
         $display("lz77_nibble_window_decoder test passed");
      end else begin
         $display("%0d errors", error_count);
         $display("lz77_nibble_window_decoder test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lznwd_pkg.sv
hw/rtl/lznwd_req_if.sv
hw/rtl/lznwd_rsp_if.sv
hw/rtl/lznwd_cell.sv
hw/rtl/lz77_nibble_window_decoder.sv
tb/sv/testbench.sv
